@@ hw/rtl/swmm_pkg.sv @@
package swmm_pkg;

   localparam int WINDOW_MAX   = 1024;
   localparam int SAMPLE_WIDTH = 32;

   // window position and length widths
   localparam int POS_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int LEN_W = $clog2(WINDOW_MAX + 1);

   // register field widths
   localparam int CFG_LEN_W    = 11;
   localparam int CFG_LEN_RST  = 100;
   localparam int CSR_ADDR_W   = 3;
   localparam int CSR_DATA_W   = 32;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef enum logic [0:0] {
      REG_WINDOW_LENGTH = 1'b0,
      REG_MODE          = 1'b1
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } seq_state_type;

   // settings handed from the register block to the sequencer
   typedef struct packed {
      logic [LEN_W-1:0] length;   // effective window length, 1 to WINDOW_MAX
      logic             mode_max; // 1 tracks the maximum
      logic             restart;  // pulse on a window_length write
   } cfg_type;

   // a is strictly more extreme than b
   function automatic logic beats(input logic mode_max, input sample_type a,
                                  input sample_type b);
      beats = mode_max ? (a > b) : (a < b);
   endfunction

endpackage

@@ hw/rtl/swmm_cell.sv @@
module swmm_cell import swmm_pkg::*; (
   input  logic       clock,
   input  logic       shift_en,
   input  sample_type d_in,
   output sample_type q
);

   sample_type cell_ff;
   sample_type cell_in;

   // take the neighbour's sample on every shift, hold otherwise
   always_comb begin
      cell_in = shift_en ? d_in : cell_ff;
   end

   always_ff @(posedge clock) begin
      cell_ff <= cell_in;
   end

   assign q = cell_ff;

endmodule

@@ hw/rtl/swmm_seq.sv @@
module swmm_seq import swmm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  cfg_type    cfg,
   input  logic       req_valid,
   output logic       req_ready,
   input  sample_type req_sample,
   input  logic       req_restart,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output sample_type rsp_extreme,
   input  sample_type head_q,
   output sample_type tail_d,
   output logic       shift_en
);

   localparam logic [POS_W-1:0] LAST_STEP = POS_W'(WINDOW_MAX - 1);

   seq_state_type state_ff, state_in;

   logic [POS_W-1:0] step_ff;
   logic             awaiting_ff;
   logic [POS_W-1:0] pos_ff;
   sample_type       cur_ff;
   logic             rsp_valid_ff;

   // per-item working registers
   sample_type       key_ff;
   sample_type       old_ff;
   logic             aw_ff;
   logic [POS_W-1:0] ipos_ff;
   sample_type       popped_ff;
   sample_type       best_ff;
   logic             found_ff;
   sample_type       match_ff;
   sample_type       rsp_extreme_ff;

   logic             accept;
   logic             out_free;
   logic             finish_go;
   logic             aw_new;
   logic [POS_W-1:0] pos_base;
   logic [POS_W-1:0] pos_start;
   logic             at_pos;
   logic             in_win;
   logic             fill;
   sample_type       elem;
   sample_type       result;
   logic [LEN_W-1:0] pos_inc;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_SCAN;
         end
         ST_SCAN: begin
            if (step_ff == LAST_STEP) state_in = ST_FINISH;
         end
         ST_FINISH: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs of the sequencer
   always_comb begin
      req_ready = 1'b0;
      shift_en  = 1'b0;
      finish_go = 1'b0;
      case (state_ff)
         ST_IDLE:   req_ready = 1'b1;
         ST_SCAN:   shift_en  = 1'b1;
         ST_FINISH: finish_go = out_free;
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign accept   = req_valid && req_ready;

   // a restart pulse in the same cycle (req_restart or a window_length write) restarts this beat too
   always_comb begin
      aw_new    = awaiting_ff | req_restart | cfg.restart;
      pos_base  = (req_restart || cfg.restart) ? '0 : pos_ff;
      pos_start = (LEN_W'(pos_base) >= cfg.length) ? '0 : pos_base;
   end

   // element at the head, with the prefill and the new sample laid over it
   always_comb begin
      at_pos = (step_ff == ipos_ff);
      in_win = (LEN_W'(step_ff) < cfg.length);
      fill   = at_pos || (aw_ff && in_win);
      elem   = fill ? key_ff : head_q;
      tail_d = elem;
   end

   always_comb begin
      if (beats(cfg.mode_max, key_ff, old_ff)) begin
         result = key_ff;
      end else if (!beats(cfg.mode_max, old_ff, popped_ff)) begin
         result = found_ff ? match_ff : best_ff;
      end else begin
         result = old_ff;
      end
      pos_inc = LEN_W'(ipos_ff) + LEN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         step_ff      <= '0;
         awaiting_ff  <= 1'b1;
         pos_ff       <= '0;
         cur_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (cfg.restart) begin
            awaiting_ff <= 1'b1;
            pos_ff      <= '0;
         end
         if (accept) begin
            step_ff  <= '0;
            found_ff <= 1'b0;
         end
         if (shift_en) begin
            step_ff <= step_ff + POS_W'(1);
            if (in_win && !found_ff && !beats(cfg.mode_max, old_ff, elem)) begin
               found_ff <= 1'b1;
            end
         end
         if (finish_go) begin
            cur_ff       <= result;
            awaiting_ff  <= 1'b0;
            pos_ff       <= (pos_inc >= cfg.length) ? '0 : POS_W'(pos_inc);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         key_ff  <= req_sample;
         aw_ff   <= aw_new;
         ipos_ff <= pos_start;
         old_ff  <= aw_new ? req_sample : cur_ff;
      end
      if (shift_en) begin
         if (at_pos) popped_ff <= aw_ff ? key_ff : head_q;
         if (in_win) begin
            if (step_ff == '0 || beats(cfg.mode_max, elem, best_ff)) best_ff <= elem;
            if (!found_ff && !beats(cfg.mode_max, old_ff, elem)) match_ff <= elem;
         end
      end
      if (finish_go) rsp_extreme_ff <= result;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_extreme = rsp_extreme_ff;

endmodule

@@ hw/rtl/sliding_window_min_max_top.sv @@
// channel   direction  ports                                   beat taken when
// req       in         req_sample, req_restart                 req_valid & req_ready
// rsp       out        rsp_extreme                             rsp_valid & rsp_ready
// csr       in/out     psel, penable, pwrite, paddr, pwdata,   psel & penable & pwrite
//                      prdata, pready                          (pready tied high)
//
// One item passes through the accept state, one full rotation of the sample cell row (every
// position passes the head once) and a settle step for the result.
// Reset gives window_length 100, minimum mode and an empty window; the next sample fills it.
// A result waiting on rsp_ready holds the settle step, and no new req beat is taken until
// that result has moved into the output register.
module sliding_window_min_max_top import swmm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  sample_type            req_sample,
   input  logic                  req_restart,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output sample_type            rsp_extreme,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [CFG_LEN_W-1:0] window_length_ff, window_length_in;
   logic                 mode_ff, mode_in;
   logic                 restart_ff, restart_in;

   reg_index_type        csr_index;
   logic                 csr_write;
   cfg_type              cfg;
   logic [LEN_W-1:0]     len_eff;

   sample_type           cell_q [WINDOW_MAX];
   sample_type           head_q;
   sample_type           tail_d;
   logic                 shift_en;

   assign pready    = 1'b1;
   assign csr_index = reg_index_type'(paddr[CSR_ADDR_W-1:2]);
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      window_length_in = window_length_ff;
      mode_in          = mode_ff;
      restart_in       = 1'b0;
      if (csr_write) begin
         case (csr_index)
            REG_WINDOW_LENGTH: begin
               window_length_in = pwdata[CFG_LEN_W-1:0];
               restart_in       = 1'b1;
            end
            REG_MODE: mode_in = pwdata[0];
            default: begin
               mode_in = mode_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_length_ff <= CFG_LEN_W'(CFG_LEN_RST);
         mode_ff          <= 1'b0;
         restart_ff       <= 1'b0;
      end else begin
         window_length_ff <= window_length_in;
         mode_ff          <= mode_in;
         restart_ff       <= restart_in;
      end
   end

   always_comb begin
      case (csr_index)
         REG_WINDOW_LENGTH: prdata = CSR_DATA_W'(window_length_ff);
         REG_MODE:          prdata = CSR_DATA_W'(mode_ff);
         default:           prdata = '0;
      endcase
   end

   // zero acts as one, anything above the store depth as the full depth
   always_comb begin
      if (window_length_ff == '0) begin
         len_eff = LEN_W'(1);
      end else if (32'(window_length_ff) > 32'(WINDOW_MAX)) begin
         len_eff = LEN_W'(WINDOW_MAX);
      end else begin
         len_eff = LEN_W'(window_length_ff);
      end
      cfg.length   = len_eff;
      cfg.mode_max = mode_ff;
      cfg.restart  = restart_ff;
   end

   // row of sample cells: each shifts towards the head, the tail takes the written-back sample
   for (genvar i = 0; i < WINDOW_MAX; i++) begin : g_cell
      if (i == WINDOW_MAX - 1) begin : g_tail
         swmm_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (tail_d),
            .q        (cell_q[i])
         );
      end else begin : g_body
         swmm_cell u_cell (
            .clock    (clock),
            .shift_en (shift_en),
            .d_in     (cell_q[i+1]),
            .q        (cell_q[i])
         );
      end
   end

   assign head_q = cell_q[0];

   swmm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_sample  (req_sample),
      .req_restart (req_restart),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_extreme (rsp_extreme),
      .head_q      (head_q),
      .tail_d      (tail_d),
      .shift_en    (shift_en)
   );

endmodule

@@ hw/rtl/swmm_checker.sv @@
module swmm_checker import swmm_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input sample_type rsp_extreme,
   input logic       pready
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_extreme))
      else $error("result changed or dropped while stalled");

   // busy straight after taking a beat
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("input taken twice in a row");

   // a result only appears after work with the input closed
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(!req_ready))
      else $error("result appeared without work");

   a_pready_high: assert property (@(posedge clock) disable iff (reset)
      pready)
      else $error("pready low");

endmodule

bind sliding_window_min_max_top swmm_checker u_swmm_checker (
   .clock       (clock),
   .reset       (reset),
   .req_valid   (req_valid),
   .req_ready   (req_ready),
   .rsp_valid   (rsp_valid),
   .rsp_ready   (rsp_ready),
   .rsp_extreme (rsp_extreme),
   .pready      (pready)
);
